@@ design/cxbc_pkg.sv @@
package cxbc_pkg;

  // Input item: one byte of the buffer and its end-of-buffer mark
  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_item_t;

  // Result item: transformed byte and the copied end-of-buffer mark
  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } out_item_t;

  // Configuration port geometry and register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIPLE_XOR  = 2'd1;

  // Direction codes
  localparam logic DIR_DECRYPT = 1'b0;
  localparam logic DIR_ENCRYPT = 1'b1;

  // Chain constants
  localparam logic [7:0] KEY_INIT = 8'h5E;
  localparam logic [7:0] KEY_STEP = 8'h3D;

  // Sixteen-entry key table, indexed by position mod 16
  function automatic logic [7:0] key16(input logic [3:0] pos);
    logic [7:0] k;
    unique case (pos)
      4'd0:    k = 8'hd1;
      4'd1:    k = 8'h73;
      4'd2:    k = 8'h52;
      4'd3:    k = 8'hf6;
      4'd4:    k = 8'hd2;
      4'd5:    k = 8'h9a;
      4'd6:    k = 8'hcb;
      4'd7:    k = 8'h27;
      4'd8:    k = 8'h3e;
      4'd9:    k = 8'haf;
      4'd10:   k = 8'h59;
      4'd11:   k = 8'h31;
      4'd12:   k = 8'h37;
      4'd13:   k = 8'hb3;
      4'd14:   k = 8'he7;
      default: k = 8'ha2;
    endcase
    return k;
  endfunction

  // Three-entry key table, indexed by position mod 3
  function automatic logic [7:0] key3(input logic [1:0] pos);
    logic [7:0] k;
    unique case (pos)
      2'd1:    k = 8'hCF;
      2'd2:    k = 8'hAB;
      default: k = 8'hFC;
    endcase
    return k;
  endfunction

endpackage

@@ design/cxbc_stream_if.sv @@
interface cxbc_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ design/chained_xor_byte_cipher.sv @@
// Channel   | Dir | Handshake     | Payload
// in_stream | in  | valid/ready   | data_in[7:0], last_in
// out_stream| out | valid/ready   | data_out[7:0], last_out
// cfg       | in  | cfg_we only   | cfg_idx[1:0], cfg_data[0]
//
// Throughput is one byte per cycle while the output is not stalled; each
// accepted byte passes the input register, then the result register. The
// running key update (ciphertext + 0x3D) is combinational in the compute
// stage. Synchronous active-low reset clears the chain state, both
// configuration bits and the valid flags.
// A stalled output holds its result; the input register still takes one item.
module chained_xor_byte_cipher (
  input  logic                             clk,
  input  logic                             rst_n,
  cxbc_stream_if.sink                      in_stream,
  cxbc_stream_if.source                    out_stream,
  input  logic                             cfg_we,
  input  logic [cxbc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [cxbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cxbc_pkg::*;

  logic       direction_r;
  logic       triple_r;

  in_item_t   in_item_r;
  logic       in_valid_r;
  out_item_t  out_item_r;
  out_item_t  out_item_nxt;
  logic       out_valid_r;

  logic [7:0] chain_key_r, chain_key_nxt;
  logic [3:0] pos16_r, pos16_nxt;
  logic [1:0] pos3_r, pos3_nxt;

  logic       advance;
  logic       in_fire;

  logic [7:0] k16, k3_mask;
  logic [7:0] enc_res, dec_res, cipher;

  // Move the held item forward when the result slot is free or draining
  assign advance          = in_valid_r && (!out_valid_r || out_stream.ready);
  assign in_stream.ready  = !in_valid_r || advance;
  assign in_fire          = in_stream.valid && in_stream.ready;
  assign out_stream.valid = out_valid_r;
  assign out_stream.payload = out_item_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_DECRYPT;
      triple_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DIRECTION:  direction_r <= cfg_data[0];
        CFG_TRIPLE_XOR: triple_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Transform the held byte with the current chain state
  always_comb begin
    k16     = key16(pos16_r);
    k3_mask = triple_r ? key3(pos3_r) : 8'h00;
    enc_res = ((in_item_r.data_in ^ k3_mask) + chain_key_r) ^ k16;
    dec_res = ((in_item_r.data_in ^ k16) - chain_key_r) ^ k3_mask;
    cipher  = (direction_r == DIR_ENCRYPT) ? enc_res : in_item_r.data_in;

    out_item_nxt.data_out = (direction_r == DIR_ENCRYPT) ? enc_res : dec_res;
    out_item_nxt.last_out = in_item_r.last_in;

    if (in_item_r.last_in) begin
      chain_key_nxt = KEY_INIT;
      pos16_nxt     = 4'd0;
      pos3_nxt      = 2'd0;
    end else begin
      chain_key_nxt = cipher + KEY_STEP;
      pos16_nxt     = pos16_r + 4'd1;
      pos3_nxt      = (pos3_r >= 2'd2) ? 2'd0 : pos3_r + 2'd1;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r <= in_stream.payload;
    end
  end

  // Chain state advances with each item that reaches the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_key_r <= KEY_INIT;
      pos16_r     <= 4'd0;
      pos3_r      <= 2'd0;
    end else if (advance) begin
      chain_key_r <= chain_key_nxt;
      pos16_r     <= pos16_nxt;
      pos3_r      <= pos3_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Chain returns to its start after a byte marked last
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_item_r.last_in) |=>
      (chain_key_r == KEY_INIT && pos16_r == 4'd0 && pos3_r == 2'd0))
    else $error("chain state not cleared after last byte");

  // Position mod 3 never reaches three
  a_pos3_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos3_r != 2'd3)
    else $error("pos mod 3 out of range");

  // Both stages full and output stalled: no new item taken
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_stream.ready) |-> !in_stream.ready)
    else $error("input accepted while pipeline full");

  // An advancing item shows up as a valid result next cycle
  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced item missing at output");

  // Position mod 16 steps on a non-last item; only this counter is checked
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !in_item_r.last_in) |=> (pos16_r == $past(pos16_r) + 4'd1))
    else $error("position counter did not advance");

endmodule

@@ tb/tb_chained_xor_byte_cipher.sv @@
import cxbc_pkg::*;

// Running-key predictor plus the queue of bytes still owed by the block
class cipher_scoreboard;
  logic [7:0] chain_key;
  logic [3:0] pos16;
  logic [1:0] pos3;
  logic       dir;
  logic       triple;
  int         errors;
  out_item_t  owed_q[$];

  logic [7:0] wide_keys[16] = '{8'hd1, 8'h73, 8'h52, 8'hf6, 8'hd2, 8'h9a, 8'hcb, 8'h27,
                                8'h3e, 8'haf, 8'h59, 8'h31, 8'h37, 8'hb3, 8'he7, 8'ha2};
  logic [7:0] attr_keys[3] = '{8'hFC, 8'hCF, 8'hAB};

  function new();
    dir    = DIR_DECRYPT;
    triple = 1'b0;
    errors = 0;
    restart_chain();
  endfunction

  function void restart_chain();
    chain_key = KEY_INIT;
    pos16     = '0;
    pos3      = '0;
  endfunction

  // Mirror a register write; unused indexes change nothing
  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_DIRECTION) begin
      dir = data[0];
    end else if (idx == CFG_TRIPLE_XOR) begin
      triple = data[0];
    end
  endfunction

  function int pending();
    return owed_q.size();
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Transform one accepted byte, queue the result and advance the chain
  function void note_input(in_item_t item);
    logic [7:0] t;
    logic [7:0] cipher;
    out_item_t  res;
    if (dir == DIR_ENCRYPT) begin
      t = item.data_in;
      if (triple) t = t ^ attr_keys[pos3];
      t = t + chain_key;
      t = t ^ wide_keys[pos16];
      cipher = t;
    end else begin
      cipher = item.data_in;
      t = item.data_in ^ wide_keys[pos16];
      t = t - chain_key;
      if (triple) t = t ^ attr_keys[pos3];
    end
    res.data_out = t;
    res.last_out = item.last_in;
    owed_q = {owed_q, res};
    if (item.last_in) begin
      restart_chain();
    end else begin
      chain_key = cipher + KEY_STEP;
      pos16     = pos16 + 4'd1;
      pos3      = (pos3 == 2'd2) ? 2'd0 : pos3 + 2'd1;
    end
  endfunction

  // Compare one accepted result against the oldest owed byte
  task check_result(out_item_t got);
    out_item_t want;
    if (owed_q.size() == 0) begin
      report($sformatf("unexpected result data=%02h last=%0b", got.data_out, got.last_out));
    end else begin
      want = owed_q.pop_front();
      if (got.data_out !== want.data_out)
        report($sformatf("data_out %02h, expected %02h", got.data_out, want.data_out));
      if (got.last_out !== want.last_out)
        report($sformatf("last_out %0b, expected %0b", got.last_out, want.last_out));
    end
  endtask
endclass

module tb_chained_xor_byte_cipher;
  localparam int LIMIT        = 300000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 750;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int   cycle_count;
  bit   src_burst;
  bit   sink_burst;
  bit   hold_sink;

  cipher_scoreboard sb;

  cxbc_stream_if #(.item_t(in_item_t))  in_if ();
  cxbc_stream_if #(.item_t(out_item_t)) out_if ();

  chained_xor_byte_cipher DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one item after a random gap, hold until the block takes it
  task automatic send_byte(input logic [7:0] data, input logic last);
    int gap;
    in_item_t item;
    gap = src_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.data_in = data;
    item.last_in = last;
    in_if.payload <= item;
    in_if.valid   <= 1'b1;
    @(posedge clk iff in_if.ready);
    sb.note_input(item);
  endtask

  // Stop offering and wait for every owed result, then let the pipe settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Write both registers, optionally poke an unused index, then release the port
  task automatic setup(input logic dir, input logic triple, input bit poke_unused);
    cfg_write(CFG_DIRECTION, dir);
    cfg_write(CFG_TRIPLE_XOR, triple);
    if (poke_unused) begin
      cfg_write(($urandom_range(0, 1) == 0) ? CFG_UNUSED_A : CFG_UNUSED_B,
                CFG_DATA_W'($urandom_range(0, 1)));
    end
    cfg_we <= 1'b0;
  endtask

  // Result side: random stall per item, one long hold on request
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_sink) begin
        stall = HOLD_CYCLES;
        hold_sink = 1'b0;
      end else if (sink_burst) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 18);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk iff out_if.valid);
      sb.check_result(out_if.payload);
    end
  end

  initial begin
    logic [7:0] lead_bytes[9]  = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h5E};
    logic [7:0] trail_bytes[9] = '{8'hFF, 8'h00, 8'h3D, 8'hC3, 8'h0F, 8'hF0, 8'h81, 8'h7E, 8'hA2};
    int sent;
    int phase;
    int burst_len;
    int buf_left;
    logic dir;
    logic triple;

    sb = new();
    src_burst   = 1'b0;
    sink_burst  = 1'b0;
    hold_sink   = 1'b0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_DIRECTION;
    cfg_data      <= '0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one buffer that wraps both position counters, with a
    // direction and layer switch halfway through
    setup(DIR_DECRYPT, 1'b0, 1'b1);
    foreach (lead_bytes[i]) send_byte(lead_bytes[i], 1'b0);
    drain();
    setup(DIR_ENCRYPT, 1'b1, 1'b1);
    foreach (trail_bytes[i]) send_byte(trail_bytes[i], i == 8);
    drain();

    // Directed: single-byte buffers back to back
    setup(DIR_DECRYPT, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    drain();
    setup(DIR_ENCRYPT, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b1);
    drain();

    // Random buffers across phases; phases often end mid-buffer
    sent = 0;
    phase = 0;
    buf_left = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase < 4) begin
        {dir, triple} = phase[1:0];
      end else begin
        dir    = 1'($urandom_range(0, 1));
        triple = 1'($urandom_range(0, 1));
      end
      setup(dir, triple, $urandom_range(0, 3) == 0);
      src_burst  = ($urandom_range(0, 2) == 0);
      sink_burst = ($urandom_range(0, 2) == 0);
      // Hold the result side long while items keep coming
      if (phase == 2) begin
        hold_sink = 1'b1;
        src_burst = 1'b1;
      end
      burst_len = $urandom_range(30, 120);
      repeat (burst_len) begin
        if (buf_left == 0) begin
          buf_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        end
        buf_left--;
        send_byte(8'($urandom_range(0, 255)), buf_left == 0);
        sent++;
      end
      drain();
      phase++;
    end

    if (sb.pending() != 0) sb.report("results still owed at end of run");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
